// ===== rtl/core/saq_pkg.sv =====
package saq_pkg;

    // Stream field widths
    localparam int IN_WIDTH  = 16;
    localparam int FRAC_BITS = 14;
    localparam int OUT_WIDTH = 16;
    localparam int IN_FIELDS = 9;
    localparam int IN_BITS   = IN_WIDTH * IN_FIELDS;
    localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 4 * OUT_WIDTH;
    localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;
    localparam int KIND_W    = 3;

    // Internal fixed point: unit values carry QB fraction bits
    localparam int QB   = 30;
    localparam int NW   = QB + 4;       // signed normalizer input
    localparam int MW   = NW - 1;       // magnitude of a normalizer input
    localparam int BW   = QB + 1;       // aligned magnitude, at most 2^QB
    localparam int QW   = QB + 2;       // signed unit component
    localparam int DIVW = 2 * QB + 3;   // dividend width
    localparam int RW   = 2 * QB + 4;   // square root work width

    localparam longint Q_ONE       = longint'(1) << QB;
    localparam longint OPP_EPS     = 1074;
    localparam longint ZERO_LEN_SQ = 1152922;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    // Sideband carried along the normalizer
    localparam int TAG_W = 3 * IN_WIDTH + 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_SAME    = 3'd0,
        KIND_OPP_FB  = 3'd1,
        KIND_OPP_GEN = 3'd2,
        KIND_GENERAL = 3'd3,
        KIND_ZERO    = 3'd4
    } kind_t;

    typedef logic signed [IN_WIDTH-1:0] comp_t;

    typedef struct packed {
        comp_t sx;
        comp_t sy;
        comp_t sz;
        comp_t dx;
        comp_t dy;
        comp_t dz;
        comp_t fx;
        comp_t fy;
        comp_t fz;
        logic  zero_in;
        logic  has_fb;
    } rec_t;

    typedef logic signed [NW-1:0] nval_t;
    typedef nval_t nvec_t [4];
    typedef logic signed [QW-1:0] qval_t;
    typedef qval_t qvec_t [4];
    typedef logic [TAG_W-1:0] tag_t;

endpackage

// ===== rtl/core/saq_front.sv =====
module saq_front
    import saq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [IN_TDATA-1:0] in_data,
    output logic                push_valid,
    input  logic                push_ready,
    output rec_t                push_rec
);

    logic valid_reg;
    rec_t rec_reg;
    rec_t rec_next;

    // Unpack the request and flag zero vectors and a missing fallback axis
    always_comb
    begin
        rec_next.sx = in_data[0*IN_WIDTH +: IN_WIDTH];
        rec_next.sy = in_data[1*IN_WIDTH +: IN_WIDTH];
        rec_next.sz = in_data[2*IN_WIDTH +: IN_WIDTH];
        rec_next.dx = in_data[3*IN_WIDTH +: IN_WIDTH];
        rec_next.dy = in_data[4*IN_WIDTH +: IN_WIDTH];
        rec_next.dz = in_data[5*IN_WIDTH +: IN_WIDTH];
        rec_next.fx = in_data[6*IN_WIDTH +: IN_WIDTH];
        rec_next.fy = in_data[7*IN_WIDTH +: IN_WIDTH];
        rec_next.fz = in_data[8*IN_WIDTH +: IN_WIDTH];
        rec_next.zero_in = (in_data[0 +: 3*IN_WIDTH] == '0)
                        || (in_data[3*IN_WIDTH +: 3*IN_WIDTH] == '0);
        rec_next.has_fb  = (in_data[6*IN_WIDTH +: 3*IN_WIDTH] != '0);
    end

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_rec   = rec_reg;

    // Hold one classified request until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rec_reg <= rec_next;
        end
    end

endmodule

// ===== rtl/core/saq_fifo.sv =====
module saq_fifo
    import saq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  rec_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output rec_t rd_data
);

    rec_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/saq_norm.sv =====
module saq_norm
    import saq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  nvec_t in_vec,
    input  tag_t  in_tag,
    output logic  out_valid,
    output qvec_t out_vec,
    output tag_t  out_tag
);

    localparam int SQ_STEPS  = RW / 2;
    localparam int DIV_STEPS = QB + 1;
    localparam int SH_W      = $clog2(QB);

    localparam logic [MW-1:0] M_HI = MW'(Q_ONE);
    localparam logic [MW-1:0] M_LO = MW'(Q_ONE >> 1);

    typedef struct packed {
        logic [RW-2:0]          n;
        logic [RW-1:0]          r;
        logic [3:0][BW-1:0]     b;
        logic [3:0]             neg;
        tag_t                   tag;
    } sq_t;

    typedef struct packed {
        logic [QW-1:0]          den;
        logic [3:0][DIVW-1:0]   num;
        logic [3:0][BW-1:0]     quo;
        logic [3:0]             neg;
        tag_t                   tag;
    } dv_t;

    // Stage 1: magnitudes and largest magnitude
    logic [3:0][MW-1:0] a1_reg;
    logic [3:0]         neg1_reg;
    logic [MW-1:0]      m1_reg;
    tag_t               tag1_reg;
    logic               v1_reg;
    logic [3:0][MW-1:0] a1_next;
    logic [3:0]         neg1_next;
    logic [MW-1:0]      m1_next;

    always_comb
    begin
        m1_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            neg1_next[i] = in_vec[i][NW-1];
            a1_next[i]   = in_vec[i][NW-1] ? MW'(-in_vec[i]) : MW'(in_vec[i]);
            if (a1_next[i] > m1_next)
            begin
                m1_next = a1_next[i];
            end
        end
    end

    // Stage 2: alignment shift that brings the largest into range
    logic [3:0][MW-1:0] a2_reg;
    logic [3:0]         neg2_reg;
    logic [1:0]         rsh2_reg;
    logic [SH_W-1:0]    lsh2_reg;
    tag_t               tag2_reg;
    logic               v2_reg;
    logic [1:0]         rsh2_next;
    logic [SH_W-1:0]    lsh2_next;

    always_comb
    begin
        rsh2_next = '0;
        lsh2_next = '0;
        if (m1_reg > M_HI)
        begin
            priority if ((m1_reg >> 1) <= M_HI)
            begin
                rsh2_next = 2'd1;
            end
            else if ((m1_reg >> 2) <= M_HI)
            begin
                rsh2_next = 2'd2;
            end
            else
            begin
                rsh2_next = 2'd3;
            end
        end
        else if (m1_reg < M_LO)
        begin
            for (int p = 0; p < QB - 1; p++)
            begin
                if (m1_reg[p])
                begin
                    lsh2_next = SH_W'(QB - 1 - p);
                end
            end
        end
    end

    // Stage 3: apply the shift
    logic [3:0][BW-1:0] b3_reg;
    logic [3:0]         neg3_reg;
    tag_t               tag3_reg;
    logic               v3_reg;
    logic [3:0][BW-1:0] b3_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (rsh2_reg != '0)
            begin
                b3_next[i] = BW'(a2_reg[i] >> rsh2_reg);
            end
            else
            begin
                b3_next[i] = BW'(a2_reg[i] << lsh2_reg);
            end
        end
    end

    // Stage 4: squares
    logic [3:0][2*BW-1:0] sq4_reg;
    logic [3:0][BW-1:0]   b4_reg;
    logic [3:0]           neg4_reg;
    tag_t                 tag4_reg;
    logic                 v4_reg;

    // Square root chain, one result bit per stage
    sq_t                 sq_reg [SQ_STEPS+1];
    logic [SQ_STEPS:0]   sq_vld_reg;
    sq_t                 sq0_next;

    always_comb
    begin
        sq0_next.n   = (RW-1)'(sq4_reg[0]) + (RW-1)'(sq4_reg[1])
                     + (RW-1)'(sq4_reg[2]) + (RW-1)'(sq4_reg[3]);
        sq0_next.r   = '0;
        sq0_next.b   = b4_reg;
        sq0_next.neg = neg4_reg;
        sq0_next.tag = tag4_reg;
    end

    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        sq_t sq_next;

        always_comb
        begin
            logic [RW-1:0] bitv;
            logic [RW-1:0] trial;
            sq_next = sq_reg[j];
            bitv    = RW'(1) << (RW - 2 - 2 * j);
            trial   = sq_reg[j].r + bitv;
            if ({1'b0, sq_reg[j].n} >= trial)
            begin
                sq_next.n = (RW-1)'({1'b0, sq_reg[j].n} - trial);
                sq_next.r = (sq_reg[j].r >> 1) + bitv;
            end
            else
            begin
                sq_next.r = sq_reg[j].r >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_vld_reg[j+1] <= sq_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[j+1] <= sq_next;
            end
        end
    end

    // Division chain, one quotient bit per stage
    dv_t                dv_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0] dv_vld_reg;
    dv_t                dv0_next;

    always_comb
    begin
        logic [QW-1:0] len;
        len          = QW'(sq_reg[SQ_STEPS].r);
        dv0_next.den = (len == '0) ? QW'(1) : len;
        for (int i = 0; i < 4; i++)
        begin
            dv0_next.num[i] = (DIVW'(sq_reg[SQ_STEPS].b[i]) << QB)
                            + DIVW'(dv0_next.den >> 1);
        end
        dv0_next.quo = '0;
        dv0_next.neg = sq_reg[SQ_STEPS].neg;
        dv0_next.tag = sq_reg[SQ_STEPS].tag;
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        dv_t dv_next;

        always_comb
        begin
            logic [DIVW-1:0] sub;
            dv_next = dv_reg[j];
            sub     = DIVW'(dv_reg[j].den) << (QB - j);
            for (int i = 0; i < 4; i++)
            begin
                if (dv_reg[j].num[i] >= sub)
                begin
                    dv_next.num[i]          = dv_reg[j].num[i] - sub;
                    dv_next.quo[i][QB - j]  = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[j+1] <= dv_next;
            end
        end
    end

    // Clamp to one and restore signs
    qvec_t out_vec_reg;
    tag_t  out_tag_reg;
    logic  out_valid_reg;
    qvec_t out_vec_next;

    always_comb
    begin
        logic [BW-1:0] q;
        for (int i = 0; i < 4; i++)
        begin
            q = dv_reg[DIV_STEPS].quo[i];
            if (q > BW'(Q_ONE))
            begin
                q = BW'(Q_ONE);
            end
            out_vec_next[i] = dv_reg[DIV_STEPS].neg[i] ? -$signed(QW'(q)) : $signed(QW'(q));
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            sq_vld_reg[0] <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            sq_vld_reg[0] <= v4_reg;
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
            out_valid_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg      <= a1_next;
            neg1_reg    <= neg1_next;
            m1_reg      <= m1_next;
            tag1_reg    <= in_tag;
            a2_reg      <= a1_reg;
            neg2_reg    <= neg1_reg;
            rsh2_reg    <= rsh2_next;
            lsh2_reg    <= lsh2_next;
            tag2_reg    <= tag1_reg;
            b3_reg      <= b3_next;
            neg3_reg    <= neg2_reg;
            tag3_reg    <= tag2_reg;
            for (int i = 0; i < 4; i++)
            begin
                sq4_reg[i] <= b3_reg[i] * b3_reg[i];
            end
            b4_reg      <= b3_reg;
            neg4_reg    <= neg3_reg;
            tag4_reg    <= tag3_reg;
            sq_reg[0]   <= sq0_next;
            dv_reg[0]   <= dv0_next;
            out_vec_reg <= out_vec_next;
            out_tag_reg <= dv_reg[DIV_STEPS].tag;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec   = out_vec_reg;
    assign out_tag   = out_tag_reg;

endmodule

// ===== rtl/core/saq_back.sv =====
module saq_back
    import saq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rec_t                 in_rec,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_BITS-1:0]  out_data,
    output logic [KIND_W-1:0]    out_kind
);

    localparam int OSH = QB - FRAC_BITS;
    localparam logic signed [NW-1:0] DOT_ONE = NW'(Q_ONE);
    localparam logic signed [NW-1:0] DOT_OPP = NW'(OPP_EPS - Q_ONE);
    localparam logic [OUT_WIDTH-1:0] OUT_ONE = OUT_WIDTH'(longint'(1) << FRAC_BITS);

    // Round a Q2QB product back to QB fraction bits, half away from zero
    function automatic logic signed [NW-1:0] rsr_q(input logic signed [2*QW-1:0] x);
        logic [2*QW-1:0] mg;
        logic [2*QW-1:0] u;
        mg = x[2*QW-1] ? (2*QW)'(-x) : (2*QW)'(x);
        u  = (mg + ((2*QW)'(1) << (QB - 1))) >> QB;
        return x[2*QW-1] ? -$signed(NW'(u)) : $signed(NW'(u));
    endfunction

    // Round a unit component to the output format and saturate
    function automatic logic [OUT_WIDTH-1:0] to_out(input qval_t x);
        logic [QW-1:0] mg;
        logic [QW-1:0] u;
        mg = x[QW-1] ? QW'(-x) : QW'(x);
        u  = (mg + (QW'(1) << (OSH - 1))) >> OSH;
        if (u > QW'(OUT_ONE))
        begin
            u = QW'(OUT_ONE);
        end
        return x[QW-1] ? OUT_WIDTH'(-u) : OUT_WIDTH'(u);
    endfunction

    logic en;
    logic out_valid_reg;
    logic [OUT_BITS-1:0] out_data_reg;
    kind_t out_kind_reg;

    // Stall the whole back end only while a result waits unclaimed
    assign en       = !(out_valid_reg && !out_ready);
    assign in_ready = en;

    // Unit vectors of start and destination
    nvec_t s_vec;
    nvec_t d_vec;
    tag_t  a_tag;
    qvec_t u0;
    qvec_t u1;
    tag_t  u_tag;
    logic  u_valid;

    always_comb
    begin
        s_vec[0] = NW'($signed(in_rec.sx));
        s_vec[1] = NW'($signed(in_rec.sy));
        s_vec[2] = NW'($signed(in_rec.sz));
        s_vec[3] = '0;
        d_vec[0] = NW'($signed(in_rec.dx));
        d_vec[1] = NW'($signed(in_rec.dy));
        d_vec[2] = NW'($signed(in_rec.dz));
        d_vec[3] = '0;
        a_tag    = {in_rec.fx, in_rec.fy, in_rec.fz, in_rec.zero_in, in_rec.has_fb};
    end

    saq_norm u_norm_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_vec    (s_vec),
        .in_tag    (a_tag),
        .out_valid (u_valid),
        .out_vec   (u0),
        .out_tag   (u_tag)
    );

    saq_norm u_norm_d (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_vec    (d_vec),
        .in_tag    ('0),
        .out_valid (),
        .out_vec   (u1),
        .out_tag   ()
    );

    // Products for dot, cross and the generated axis length
    logic signed [2*QW-1:0] pd_reg [3];
    logic signed [2*QW-1:0] pc_reg [6];
    logic signed [2*QW-1:0] psq_reg [2];
    qval_t                  u0_b1_reg [3];
    tag_t                   tag_b1_reg;
    logic                   v_b1_reg;

    // Rounded sums
    logic signed [NW-1:0]   dot_b2_reg;
    logic signed [NW-1:0]   cr_b2_reg [3];
    logic                   small_b2_reg;
    qval_t                  u0_b2_reg [3];
    tag_t                   tag_b2_reg;
    logic                   v_b2_reg;

    // Case selection and vector for the final normalization
    kind_t  kind_next;
    nvec_t  vec_next;
    kind_t  kind_b3_reg;
    nvec_t  vec_b3_reg;
    logic   v_b3_reg;
    tag_t   kind_tag;
    qvec_t  q;
    tag_t   q_tag;
    logic   q_valid;

    always_comb
    begin
        logic zero_in;
        logic has_fb;
        zero_in = tag_b2_reg[1];
        has_fb  = tag_b2_reg[0];
        vec_next[0] = DOT_ONE + dot_b2_reg;
        vec_next[1] = cr_b2_reg[0];
        vec_next[2] = cr_b2_reg[1];
        vec_next[3] = cr_b2_reg[2];
        priority if (zero_in)
        begin
            kind_next = KIND_ZERO;
        end
        else if (dot_b2_reg >= DOT_ONE)
        begin
            kind_next = KIND_SAME;
        end
        else if (dot_b2_reg < DOT_OPP)
        begin
            vec_next[0] = '0;
            if (has_fb)
            begin
                kind_next   = KIND_OPP_FB;
                vec_next[1] = NW'($signed(tag_b2_reg[2+2*IN_WIDTH +: IN_WIDTH]));
                vec_next[2] = NW'($signed(tag_b2_reg[2+IN_WIDTH +: IN_WIDTH]));
                vec_next[3] = NW'($signed(tag_b2_reg[2 +: IN_WIDTH]));
            end
            else if (small_b2_reg)
            begin
                kind_next   = KIND_OPP_GEN;
                vec_next[1] = NW'(u0_b2_reg[2]);
                vec_next[2] = '0;
                vec_next[3] = NW'(-u0_b2_reg[0]);
            end
            else
            begin
                kind_next   = KIND_OPP_GEN;
                vec_next[1] = '0;
                vec_next[2] = NW'(-u0_b2_reg[2]);
                vec_next[3] = NW'(u0_b2_reg[1]);
            end
        end
        else
        begin
            kind_next = KIND_GENERAL;
        end
    end

    assign kind_tag = TAG_W'(kind_b3_reg);

    saq_norm u_norm_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_b3_reg),
        .in_vec    (vec_b3_reg),
        .in_tag    (kind_tag),
        .out_valid (q_valid),
        .out_vec   (q),
        .out_tag   (q_tag)
    );

    // Valids of the middle stages and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b1_reg      <= 1'b0;
            v_b2_reg      <= 1'b0;
            v_b3_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_b1_reg      <= u_valid;
            v_b2_reg      <= v_b1_reg;
            v_b3_reg      <= v_b2_reg;
            out_valid_reg <= q_valid;
        end
    end

    // Payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg[0]  <= u0[0] * u1[0];
            pd_reg[1]  <= u0[1] * u1[1];
            pd_reg[2]  <= u0[2] * u1[2];
            pc_reg[0]  <= u0[1] * u1[2];
            pc_reg[1]  <= u0[2] * u1[1];
            pc_reg[2]  <= u0[2] * u1[0];
            pc_reg[3]  <= u0[0] * u1[2];
            pc_reg[4]  <= u0[0] * u1[1];
            pc_reg[5]  <= u0[1] * u1[0];
            psq_reg[0] <= u0[1] * u0[1];
            psq_reg[1] <= u0[2] * u0[2];
            for (int i = 0; i < 3; i++)
            begin
                u0_b1_reg[i] <= u0[i];
                u0_b2_reg[i] <= u0_b1_reg[i];
            end
            tag_b1_reg   <= u_tag;

            dot_b2_reg   <= rsr_q(pd_reg[0] + pd_reg[1] + pd_reg[2]);
            cr_b2_reg[0] <= rsr_q(pc_reg[0] - pc_reg[1]);
            cr_b2_reg[1] <= rsr_q(pc_reg[2] - pc_reg[3]);
            cr_b2_reg[2] <= rsr_q(pc_reg[4] - pc_reg[5]);
            small_b2_reg <= (psq_reg[0] + psq_reg[1]) < (2*QW)'(ZERO_LEN_SQ);
            tag_b2_reg   <= tag_b1_reg;

            kind_b3_reg  <= kind_next;
            vec_b3_reg   <= vec_next;

            if (q_valid)
            begin
                out_kind_reg <= kind_t'(q_tag[KIND_W-1:0]);
                if (kind_t'(q_tag[KIND_W-1:0]) == KIND_SAME
                    || kind_t'(q_tag[KIND_W-1:0]) == KIND_ZERO)
                begin
                    out_data_reg <= {{(3*OUT_WIDTH){1'b0}}, OUT_ONE};
                end
                else
                begin
                    out_data_reg <= {to_out(q[3]), to_out(q[2]), to_out(q[1]), to_out(q[0])};
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_kind  = out_kind_reg;

endmodule

// ===== rtl/core/shortest_arc_quaternion_core.sv =====
// Shortest-arc rotation quaternion between a start and a destination vector.
// Each request on the slave stream carries start, destination and an optional
// fallback axis as signed 16-bit integers; each result on the master stream
// is the unit quaternion (w, x, y, z) in Q2.14 plus a case code in tuser
// (same, opposite with fallback, opposite with generated axis, general, zero
// input). One request is accepted per clock and one result leaves per clock
// in steady state while the master stream is not stalled. A one-stage input
// register and a four-entry queue feed a pipeline of two normalizer levels in
// series (start and destination in parallel, then the result), each normalizer
// a 32-stage square root and a 31-stage divider at one bit per stage, plus
// three stages for the dot and cross products and case selection. A stalled
// result freezes the pipeline; the queue keeps taking requests until it fills.
module shortest_arc_quaternion_core
    import saq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // start_x, start_y, start_z, dest_x, dest_y, dest_z,
    // fallback_x, fallback_y, fallback_z
    input  logic [IN_TDATA-1:0]  s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [OUT_TDATA-1:0] m_axis_tdata,
    // case_taken
    output logic [KIND_W-1:0]    m_axis_tuser
);

    logic push_valid;
    logic push_ready;
    rec_t push_rec;
    logic pop_valid;
    logic pop_ready;
    rec_t pop_rec;
    logic [OUT_BITS-1:0] out_data;

    saq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    saq_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_rec),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_rec)
    );

    saq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop_valid),
        .in_ready  (pop_ready),
        .in_rec    (pop_rec),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data),
        .out_kind  (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDATA'(out_data);

endmodule

// ===== rtl/core/saq_checker.sv =====
module saq_checker
    import saq_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_TDATA-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]    m_axis_tuser
);

    localparam logic [OUT_WIDTH-1:0] OUT_ONE = OUT_WIDTH'(longint'(1) << FRAC_BITS);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Same direction and zero input give the identity
    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_SAME || m_axis_tuser == KIND_ZERO)
        |-> m_axis_tdata[OUT_BITS-1:0] == {{(3*OUT_WIDTH){1'b0}}, OUT_ONE})
        else $error("identity case carries a non-identity quaternion");

    // Half turns have a zero scalar part
    a_half_turn: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_OPP_FB || m_axis_tuser == KIND_OPP_GEN)
        |-> m_axis_tdata[OUT_WIDTH-1:0] == '0)
        else $error("half turn with nonzero scalar part");

endmodule

bind shortest_arc_quaternion_core saq_checker u_saq_checker (.*);
